/* hw/rtl/checksum_byte_stuffing_tx_top_macros.svh */
// Assertion macros for the checksum byte-stuffing transmitter checker.
// Depends on nothing; included by cbst_checker.sv by bare name.
`ifndef CHECKSUM_BYTE_STUFFING_TX_TOP_MACROS_SVH
`define CHECKSUM_BYTE_STUFFING_TX_TOP_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define CBST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CBST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/cbst_pkg.sv */
// Package for the checksum byte-stuffing transmitter: constants, queue entry
// and back-end phase types. No dependencies.
`timescale 1ns / 1ps

package cbst_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH_D = 4;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAG   = 2'd0,
        REG_ESCAPE = 2'd1
    } cfg_reg_t;

    // One accepted message byte, already classified.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_esc;
        logic              last;
        logic [BYTE_W-1:0] chk;
        logic              chk_esc;
    } entry_t;

    typedef enum logic [3:0] {
        PH_DATA_ESC = 4'b0001,
        PH_DATA     = 4'b0010,
        PH_CHK_ESC  = 4'b0100,
        PH_CHK      = 4'b1000
    } phase_t;

endpackage

/* hw/rtl/cbst_front.sv */
// Front end: configuration registers, input acceptance, running checksum and
// escape classification. Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_front import cbst_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output entry_t               q_entry,
    output logic [BYTE_W-1:0]    escape_value
);

    logic [BYTE_W-1:0] flag_reg, flag_next;
    logic [BYTE_W-1:0] escape_reg, escape_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W:0]   raw_sum;
    logic [BYTE_W-1:0] folded;

    assign cfg_ready    = 1'b1;
    assign s_tready     = !q_full;
    assign q_push       = s_tvalid && !q_full;
    assign escape_value = escape_reg;

    always_comb begin
        flag_next   = flag_reg;
        escape_next = escape_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FLAG:   flag_next   = cfg_data;
                REG_ESCAPE: escape_next = cfg_data;
                default:    ;
            endcase
        end
    end

    // End-around carry: one fold always suffices.
    assign raw_sum = {1'b0, sum_reg} + {1'b0, s_tdata};
    assign folded  = raw_sum[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, raw_sum[BYTE_W]};

    always_comb begin
        sum_next = sum_reg;
        if (q_push) begin
            sum_next = s_tlast ? '0 : folded;
        end
    end

    always_comb begin
        q_entry.data     = s_tdata;
        q_entry.data_esc = (s_tdata == flag_reg) || (s_tdata == escape_reg);
        q_entry.last     = s_tlast;
        q_entry.chk      = ~folded;
        q_entry.chk_esc  = (~folded == flag_reg) || (~folded == escape_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= FLAG_RESET;
            escape_reg <= ESCAPE_RESET;
            sum_reg    <= '0;
        end else begin
            flag_reg   <= flag_next;
            escape_reg <= escape_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

/* hw/rtl/cbst_queue.sv */
// Short queue of classified entries between front and back ends.
// Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_queue import cbst_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_D
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/cbst_back.sv */
// Back end: walks each queued entry through escape and data phases (a last one
// also escape and checksum) into a registered output word. Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_back import cbst_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  entry_t            head,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [BYTE_W-1:0] escape_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    phase_t            phase_reg, phase_next, cur;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              check_reg, check_next;
    logic              load, done;

    assign load = !q_empty && (!valid_reg || m_tready);

    // Skip escape phases the entry does not need.
    always_comb begin
        unique case (phase_reg)
            PH_DATA_ESC: cur = head.data_esc ? PH_DATA_ESC : PH_DATA;
            PH_DATA:     cur = PH_DATA;
            PH_CHK_ESC:  cur = head.chk_esc ? PH_CHK_ESC : PH_CHK;
            PH_CHK:      cur = PH_CHK;
            default:     cur = PH_DATA;
        endcase
    end

    always_comb begin
        done       = 1'b0;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        check_next = check_reg;
        valid_next = valid_reg && !m_tready;
        unique case (cur)
            PH_DATA_ESC: begin
                byte_next  = escape_value;
                check_next = 1'b0;
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                byte_next  = head.data;
                check_next = 1'b0;
                done       = !head.last;
                phase_next = head.last ? PH_CHK_ESC : PH_DATA_ESC;
            end
            PH_CHK_ESC: begin
                byte_next  = escape_value;
                check_next = 1'b1;
                phase_next = PH_CHK;
            end
            PH_CHK: begin
                byte_next  = head.chk;
                check_next = 1'b1;
                done       = 1'b1;
                phase_next = PH_DATA_ESC;
            end
            default: ;
        endcase
        last_next = done;
        if (!load) begin
            phase_next = phase_reg;
            byte_next  = byte_reg;
            last_next  = last_reg;
            check_next = check_reg;
        end else begin
            valid_next = 1'b1;
        end
    end

    assign q_pop    = load && done;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = check_reg;

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        check_reg <= check_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA_ESC;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

endmodule

/* hw/rtl/checksum_byte_stuffing_tx_top.sv */
// Checksum byte-stuffing transmitter over cbst_front, cbst_queue and cbst_back.
// Path: accepted s_ bytes go into the queue, which absorbs bursts, then the output register.
// Throughput: one output word per cycle while m_tready is high; an input word gives
// 1 to 4 output words (escaped data, checksum), set by the back-end phase walk.
// Reset: synchronous active-low aresetn clears the sum, queue, phase and output valid;
// flag and escape registers return to 0x7E and 0x7D.
`timescale 1ns / 1ps

module checksum_byte_stuffing_tx_top import cbst_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser,   // [0] is_check
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    entry_t            q_entry, q_head;
    logic              q_push, q_pop, q_full, q_empty;
    logic [BYTE_W-1:0] escape_value;

    cbst_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry),
        .escape_value (escape_value)
    );

    cbst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    cbst_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .escape_value (escape_value),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

/* hw/rtl/cbst_checker.sv */
// Port-level checker for the checksum byte-stuffing transmitter, bound to the
// top level. Depends on cbst_pkg and checksum_byte_stuffing_tx_top_macros.svh.
`timescale 1ns / 1ps
`include "checksum_byte_stuffing_tx_top_macros.svh"

module cbst_checker import cbst_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [BYTE_W-1:0]    s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [BYTE_W-1:0]    m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [BYTE_W-1:0]    cfg_data
);

    `CBST_ASSERT(a_m_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped under stall")
    `CBST_ASSERT(a_m_hold_word, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "m_ word changed under stall")
    `CBST_ASSERT(a_idle_after_reset, $rose(aresetn) |-> !m_tvalid, "output valid right after reset")
    `CBST_ASSERT(a_check_then_data, m_tvalid && m_tready && m_tuser && m_tlast |=> !(m_tvalid && m_tuser), "checksum word follows a finished checksum")

endmodule

bind checksum_byte_stuffing_tx_top cbst_checker u_cbst_checker (.*);
